[src/cbt_pkg.sv]
// Shared types, codes and the byte class and lexer step functions of the CSV byte tokenizer.
package cbt_pkg;

  localparam int unsigned MaxEv     = 4;
  localparam int unsigned EvIdxW    = $clog2(MaxEv);
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned LexSteps  = 4;

  localparam logic EvChar = 1'b0;
  localparam logic EvEnd  = 1'b1;

  typedef enum logic [7:0] {
    LX_BEGIN   = 8'b0000_0001,
    LX_SYMBOL  = 8'b0000_0010,
    LX_STRING  = 8'b0000_0100,
    LX_QUOTE   = 8'b0000_1000,
    LX_BSLASH  = 8'b0001_0000,
    LX_EOL     = 8'b0010_0000,
    LX_EOF     = 8'b0100_0000,
    LX_ILLEGAL = 8'b1000_0000
  } lex_state_e;

  typedef enum logic [3:0] {
    CL_OTHER,
    CL_QUOTE,
    CL_COMMA,
    CL_PLAIN,
    CL_BSLASH,
    CL_LF,
    CL_CR,
    CL_DEL,
    CL_EOF
  } cls_e;

  typedef enum logic [2:0] {
    TK_STRING  = 3'd0,
    TK_COMMA   = 3'd1,
    TK_EOL     = 3'd2,
    TK_EOF     = 3'd3,
    TK_ILLEGAL = 3'd4
  } tok_code_e;

  // One pass of the lexer over a byte: an optional content character, then an
  // optional token end.
  typedef struct packed {
    lex_state_e nxt;
    logic       used;
    logic       start;
    logic       has_char;
    logic       has_end;
    tok_code_e  end_code;
  } lex_step_t;

  // All results of one input byte. Every result of a byte shares its line.
  typedef struct packed {
    logic [7:0]                 byte_val;
    logic [15:0]                line;
    logic [EvIdxW-1:0]          last_idx;
    logic [MaxEv-1:0]           kind;
    logic [MaxEv-1:0][2:0]      code;
    logic [MaxEv-1:0][7:0]      tok;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic cls_e classify(input logic [7:0] b);
    cls_e c;
    case (b) inside
      8'h22:                      c = CL_QUOTE;
      8'h2C:                      c = CL_COMMA;
      8'h5C:                      c = CL_BSLASH;
      8'h0A:                      c = CL_LF;
      8'h0D:                      c = CL_CR;
      8'h7F:                      c = CL_DEL;
      8'h1A:                      c = CL_EOF;
      8'h09, 8'h0C, [8'h20:8'hFF]: c = CL_PLAIN;
      default:                    c = CL_OTHER;
    endcase
    return c;
  endfunction

  function automatic lex_step_t lex_step(input lex_state_e s, input cls_e c);
    lex_step_t r;
    r.nxt      = s;
    r.used     = 1'b1;
    r.start    = 1'b0;
    r.has_char = 1'b0;
    r.has_end  = 1'b0;
    r.end_code = TK_STRING;
    case (s)
      LX_BEGIN: begin
        case (c)
          CL_CR: ;
          CL_LF: begin
            r.nxt = LX_EOL; r.start = 1'b1; r.has_char = 1'b1;
            r.has_end = 1'b1; r.end_code = TK_EOL;
          end
          CL_OTHER, CL_BSLASH, CL_PLAIN: begin
            r.nxt = LX_SYMBOL; r.start = 1'b1; r.has_char = 1'b1;
          end
          CL_QUOTE: begin
            r.nxt = LX_STRING; r.start = 1'b1;
          end
          CL_COMMA: begin
            r.start = 1'b1; r.has_char = 1'b1;
            r.has_end = 1'b1; r.end_code = TK_COMMA;
          end
          CL_EOF: begin
            r.nxt = LX_EOF; r.has_end = 1'b1; r.end_code = TK_EOF;
          end
          default: begin
            r.nxt = LX_ILLEGAL; r.start = 1'b1; r.has_char = 1'b1;
          end
        endcase
      end
      LX_SYMBOL: begin
        if (c == CL_CR) begin
          r.has_end = 1'b1; r.nxt = LX_BEGIN;
        end else if (c == CL_LF || c == CL_EOF || c == CL_COMMA) begin
          r.has_end = 1'b1; r.nxt = LX_BEGIN; r.used = 1'b0;
        end else begin
          r.has_char = 1'b1;
        end
      end
      LX_STRING: begin
        if (c == CL_BSLASH) begin
          r.nxt = LX_BSLASH;
        end else if (c == CL_QUOTE) begin
          r.nxt = LX_QUOTE;
        end else if (c == CL_CR) begin
          r.nxt = LX_QUOTE; r.used = 1'b0;
        end else if (c == CL_EOF) begin
          r.nxt = LX_BEGIN; r.has_end = 1'b1; r.used = 1'b0;
        end else begin
          r.has_char = 1'b1;
        end
      end
      LX_QUOTE: begin
        if (c == CL_QUOTE) begin
          r.nxt = LX_STRING; r.has_char = 1'b1;
        end else begin
          r.nxt = LX_BEGIN; r.has_end = 1'b1; r.used = 1'b0;
        end
      end
      LX_BSLASH: begin
        r.nxt = LX_STRING;
        if (c != CL_CR && c != CL_LF && c != CL_EOF) begin
          r.has_char = 1'b1;
        end else begin
          r.used = 1'b0;
        end
      end
      LX_EOL: begin
        if (c == CL_CR) begin
        end else if (c == CL_LF) begin
          r.start = 1'b1; r.has_char = 1'b1;
          r.has_end = 1'b1; r.end_code = TK_EOL;
        end else if (c == CL_EOF) begin
          r.nxt = LX_EOF; r.has_end = 1'b1; r.end_code = TK_EOF;
        end else begin
          r.nxt = LX_BEGIN; r.used = 1'b0;
        end
      end
      LX_EOF: begin
        r.has_end = 1'b1; r.end_code = TK_EOF;
      end
      LX_ILLEGAL: begin
        if (c == CL_OTHER || c == CL_BSLASH || c == CL_DEL) begin
          r.has_char = 1'b1;
        end else begin
          r.nxt = LX_BEGIN; r.has_end = 1'b1; r.end_code = TK_ILLEGAL; r.used = 1'b0;
        end
      end
      default: begin
        r.nxt = LX_BEGIN; r.used = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

[src/cbt_front.sv]
// Front end: classifies each byte and runs the lexer over it, building one queue entry.
module cbt_front import cbt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic [7:0] byte_i,
  output logic     push_o,
  output q_entry_t entry_o
);

  lex_state_e state_q, state_d;
  logic [15:0] line_q, line_d;
  logic [7:0]  tok_q, tok_d;

  cls_e        cls;
  lex_step_t   step;
  logic        used;
  logic        eol;
  logic [EvIdxW:0] n_ev;

  always_comb begin
    cls      = classify(byte_i);
    state_d  = state_q;
    tok_d    = tok_q;
    used     = 1'b0;
    eol      = 1'b0;
    n_ev     = '0;
    step     = lex_step(state_q, cls);
    entry_o.byte_val = byte_i;
    entry_o.line     = line_q;
    entry_o.kind     = '0;
    entry_o.code     = '0;
    entry_o.tok      = '0;
    // The byte is offered again to the lexer until some pass consumes it.
    for (int i = 0; i < LexSteps; i++) begin
      if (!used) begin
        step = lex_step(state_d, cls);
        if (step.start && tok_d != 8'hFF) begin
          tok_d = tok_d + 8'd1;
        end
        if (step.has_char && n_ev < (EvIdxW + 1)'(MaxEv)) begin
          entry_o.kind[n_ev[EvIdxW-1:0]] = EvChar;
          entry_o.tok[n_ev[EvIdxW-1:0]]  = tok_d;
          n_ev = n_ev + 1'b1;
        end
        if (step.has_end && n_ev < (EvIdxW + 1)'(MaxEv)) begin
          entry_o.kind[n_ev[EvIdxW-1:0]] = EvEnd;
          entry_o.code[n_ev[EvIdxW-1:0]] = step.end_code;
          entry_o.tok[n_ev[EvIdxW-1:0]]  = tok_d;
          n_ev = n_ev + 1'b1;
        end
        if (step.has_end && step.end_code == TK_EOL) begin
          eol = 1'b1;
        end
        state_d = step.nxt;
        used    = step.used;
      end
    end
    entry_o.last_idx = EvIdxW'(n_ev - 1'b1);
    push_o = accept_i && (n_ev != '0);
    line_d = line_q;
    // An end-of-line token is always the final result of its byte.
    if (eol) begin
      tok_d = '0;
      if (line_q != 16'hFFFF) begin
        line_d = line_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LX_BEGIN;
      line_q  <= 16'd1;
      tok_q   <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
      line_q  <= line_d;
      tok_q   <= tok_d;
    end
  end

endmodule

[src/cbt_queue.sv]
// Short queue of per-byte result entries between the front and back ends.
module cbt_queue import cbt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output q_entry_t entry_o,
  output q_stat_t  stat_o
);

  q_entry_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == (QPtrW + 1)'(QDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[src/cbt_back.sv]
// Back end: feeds head-entry results to the output register, one per unstalled cycle.
module cbt_back import cbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_entry_t    entry_i,
  input  q_stat_t     stat_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        kind_o,
  output logic [7:0]  char_o,
  output logic [2:0]  code_o,
  output logic [15:0] line_o,
  output logic [7:0]  tok_o,
  output logic        last_o
);

  logic [EvIdxW-1:0] idx_q;
  logic              load;
  logic              at_last;

  assign load    = !stat_i.empty && (!valid_o || ready_i);
  assign at_last = (idx_q == entry_i.last_idx);
  assign pop_o   = load && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_o <= 1'b1;
        idx_q   <= at_last ? '0 : idx_q + 1'b1;
      end else if (ready_i) begin
        valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o <= entry_i.kind[idx_q];
      char_o <= (entry_i.kind[idx_q] == EvChar) ? entry_i.byte_val : 8'd0;
      code_o <= (entry_i.kind[idx_q] == EvEnd) ? entry_i.code[idx_q] : 3'd0;
      line_o <= entry_i.line;
      tok_o  <= entry_i.tok[idx_q];
      last_o <= at_last;
    end
  end

endmodule

[src/csv_byte_tokenizer_top.sv]
// Top level of the CSV byte tokenizer: front end, result queue and output back end.
//
//   Channel  Direction  Transfer when                  Payload
//   s_axis   in         s_axis_tvalid & s_axis_tready  tdata[7:0] = in_byte
//   m_axis   out        m_axis_tvalid & m_axis_tready  tuser = event_kind, tlast = last,
//                                                     tdata = char_value, token_code,
//                                                     line_count, token_index
//
// The front end takes one byte per cycle whenever the four-entry queue has room; the
// whole lexer pass over a byte, including re-examination of an unconsumed byte, is done
// in that cycle. The back end moves one result per cycle into the output register while
// that register is empty or being taken, and pops a byte's entry only with its last
// result. Bytes that produce no result never enter the queue. Reset is asynchronous
// and active low and leaves the lexer at the start of a token, the line counter at one
// and the token counter at zero. A stall on the output side fills the queue and only
// then drops s_axis_tready.
module csv_byte_tokenizer_top import cbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] char_value, [10:8] token_code,
                                      // [26:11] line_count, [34:27] token_index, rest zero
  output logic        m_axis_tuser,   // [0] event_kind
  output logic        m_axis_tlast
);

  logic        in_accept;
  logic        push;
  logic        pop;
  q_entry_t    front_entry;
  q_entry_t    head_entry;
  q_stat_t     q_stat;
  logic [7:0]  char_value;
  logic [2:0]  token_code;
  logic [15:0] line_count;
  logic [7:0]  token_index;

  // Input transfers stop only when the queue is full.
  assign s_axis_tready = !q_stat.full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  cbt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (s_axis_tdata),
    .push_o   (push),
    .entry_o  (front_entry)
  );

  cbt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  cbt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .stat_i  (q_stat),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .kind_o  (m_axis_tuser),
    .char_o  (char_value),
    .code_o  (token_code),
    .line_o  (line_count),
    .tok_o   (token_index),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, token_index, line_count, token_code, char_value};

  // Waiting results are always moved into an empty output register.
  a_back_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat.empty && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("queued result not loaded into empty output register");

  // With nothing queued, an empty output register stays empty.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.empty && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared with empty queue");

  // An end-of-line token is always the final result of its byte.
  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EvEnd) && (token_code == TK_EOL) |-> m_axis_tlast)
    else $error("end-of-line token not marked last");

endmodule

[verif/testbench.sv]
// Self-checking CSV tokenizer testbench: directed script, comma line, random records, EOF tail.
module testbench import cbt_pkg::*; ();

  localparam int unsigned IdleLimit  = 2000;  // Cycles without any transfer before giving up.
  localparam int unsigned RandTarget = 90;    // Random bytes that produce at least one result.
  localparam int unsigned WideLine   = 262;   // Commas on the line that saturates the index.
  localparam int unsigned DrainWait  = 16;    // Cycles left for stray results at the end.

  // One result of the tokenizer, in the order the fields travel on the output stream.
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    tok_code_e  code;
    logic [15:0] line;
    logic [7:0] idx;
    logic       last;
  } token_ev_t;

  // A directed byte, with its single result typed in where it is obvious.
  typedef struct packed {
    logic [7:0] din;
    logic       typed;
    token_ev_t  ev;
  } dir_row_t;

  // The directed script walks three lines through every lexer state except end of file,
  // which is terminal and therefore only appears in the closing tail.
  localparam dir_row_t DirScript [25] = '{
    '{8'h61, 1'b1, '{EvChar, 8'h61, TK_STRING, 16'd1, 8'd1, 1'b1}},  // First symbol.
    '{8'h2C, 1'b0, '0},                                              // Comma ends symbol.
    '{8'h22, 1'b0, '0},                                              // Opening quote.
    '{8'h00, 1'b1, '{EvChar, 8'h00, TK_STRING, 16'd1, 8'd3, 1'b1}},  // Lowest byte.
    '{8'hFF, 1'b1, '{EvChar, 8'hFF, TK_STRING, 16'd1, 8'd3, 1'b1}},  // Highest byte.
    '{8'h22, 1'b0, '0},                                              // First of a pair.
    '{8'h22, 1'b1, '{EvChar, 8'h22, TK_STRING, 16'd1, 8'd3, 1'b1}},  // Doubled quote.
    '{8'h5C, 1'b0, '0},                                              // Escape ...
    '{8'h2C, 1'b0, '0},                                              // ... a comma.
    '{8'h5C, 1'b0, '0},                                              // Escape ...
    '{8'h0A, 1'b0, '0},                                              // ... an LF.
    '{8'h5C, 1'b0, '0},                                              // Escape ...
    '{8'h0D, 1'b1, '{EvEnd, 8'h00, TK_STRING, 16'd1, 8'd3, 1'b1}},   // ... a CR, ends string.
    '{8'h22, 1'b0, '0},                                              // New quoted field.
    '{8'h0D, 1'b1, '{EvEnd, 8'h00, TK_STRING, 16'd1, 8'd4, 1'b1}},   // CR ends it.
    '{8'h7F, 1'b1, '{EvChar, 8'h7F, TK_STRING, 16'd1, 8'd5, 1'b1}},  // DEL opens illegal.
    '{8'h01, 1'b0, '0},                                              // Control byte.
    '{8'h5C, 1'b0, '0},                                              // Backslash.
    '{8'h7F, 1'b0, '0},                                              // DEL again.
    '{8'h0A, 1'b0, '0},                                              // LF ends illegal.
    '{8'h0A, 1'b0, '0},                                              // Blank line.
    '{8'h0D, 1'b0, '0},                                              // CR after line end.
    '{8'h09, 1'b0, '0},                                              // Tab as symbol.
    '{8'h0D, 1'b0, '0},                                              // CR ends symbol.
    '{8'h0A, 1'b0, '0}                                               // Line end.
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  csv_byte_tokenizer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Lexer state as the tokenizer should hold it, and the results still owed by the block.
  lex_state_e  lexer_st;
  logic [15:0] row_no;
  logic [7:0]  field_no;
  token_ev_t   byte_evs[$];
  token_ev_t   pending_tokens[$];

  int unsigned fail_count = 0;
  int unsigned productive = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  function automatic cls_e class_of(input logic [7:0] b);
    if (b == 8'h22) return CL_QUOTE;
    if (b == 8'h2C) return CL_COMMA;
    if (b == 8'h5C) return CL_BSLASH;
    if (b == 8'h0A) return CL_LF;
    if (b == 8'h0D) return CL_CR;
    if (b == 8'h7F) return CL_DEL;
    if (b == 8'h1A) return CL_EOF;
    if (b == 8'h09 || b == 8'h0C || b >= 8'h20) return CL_PLAIN;
    return CL_OTHER;
  endfunction

  function automatic void open_field();
    if (field_no != 8'hFF) field_no++;
  endfunction

  function automatic void emit(input logic kind, input logic [7:0] ch, input tok_code_e code);
    token_ev_t ev;
    ev.kind = kind;
    ev.ch   = ch;
    ev.code = code;
    ev.line = row_no;
    ev.idx  = field_no;
    ev.last = 1'b0;
    if (byte_evs.size() < MaxEv) byte_evs.push_back(ev);
  endfunction

  // An end-of-line token moves to the next line only after it has been reported.
  function automatic void close_token(input tok_code_e code);
    emit(EvEnd, 8'h00, code);
    if (code == TK_EOL) begin
      if (row_no != 16'hFFFF) row_no++;
      field_no = '0;
    end
  endfunction

  // Runs the lexer over one byte and leaves its results in byte_evs. A byte that ends a
  // token without being consumed goes around the loop again.
  function automatic void lex_byte(input logic [7:0] b);
    cls_e c;
    bit   consumed;
    c = class_of(b);
    consumed = 1'b0;
    byte_evs.delete();
    for (int g = 0; g < 8 && !consumed; g++) begin
      case (lexer_st)
        LX_BEGIN: begin
          consumed = 1'b1;
          case (c)
            CL_CR: ;
            CL_LF: begin
              lexer_st = LX_EOL;
              open_field();
              emit(EvChar, b, TK_STRING);
              close_token(TK_EOL);
            end
            CL_OTHER, CL_BSLASH, CL_PLAIN: begin
              lexer_st = LX_SYMBOL;
              open_field();
              emit(EvChar, b, TK_STRING);
            end
            CL_QUOTE: begin
              lexer_st = LX_STRING;
              open_field();
            end
            CL_COMMA: begin
              open_field();
              emit(EvChar, b, TK_STRING);
              close_token(TK_COMMA);
            end
            CL_EOF: begin
              lexer_st = LX_EOF;
              close_token(TK_EOF);
            end
            default: begin
              lexer_st = LX_ILLEGAL;
              open_field();
              emit(EvChar, b, TK_STRING);
            end
          endcase
        end
        LX_SYMBOL: begin
          if (c == CL_CR) begin
            consumed = 1'b1;
            close_token(TK_STRING);
            lexer_st = LX_BEGIN;
          end else if (c == CL_LF || c == CL_EOF || c == CL_COMMA) begin
            close_token(TK_STRING);
            lexer_st = LX_BEGIN;
          end else begin
            emit(EvChar, b, TK_STRING);
            consumed = 1'b1;
          end
        end
        LX_STRING: begin
          if (c == CL_BSLASH) begin
            lexer_st = LX_BSLASH;
            consumed = 1'b1;
          end else if (c == CL_QUOTE) begin
            lexer_st = LX_QUOTE;
            consumed = 1'b1;
          end else if (c == CL_CR) begin
            lexer_st = LX_QUOTE;
          end else if (c == CL_EOF) begin
            lexer_st = LX_BEGIN;
            close_token(TK_STRING);
          end else begin
            emit(EvChar, b, TK_STRING);
            consumed = 1'b1;
          end
        end
        LX_QUOTE: begin
          if (c == CL_QUOTE) begin
            lexer_st = LX_STRING;
            emit(EvChar, b, TK_STRING);
            consumed = 1'b1;
          end else begin
            lexer_st = LX_BEGIN;
            close_token(TK_STRING);
          end
        end
        LX_BSLASH: begin
          lexer_st = LX_STRING;
          if (c != CL_CR && c != CL_LF && c != CL_EOF) begin
            emit(EvChar, b, TK_STRING);
            consumed = 1'b1;
          end
        end
        LX_EOL: begin
          if (c == CL_CR) begin
            consumed = 1'b1;
          end else if (c == CL_LF) begin
            open_field();
            emit(EvChar, b, TK_STRING);
            close_token(TK_EOL);
            consumed = 1'b1;
          end else if (c == CL_EOF) begin
            lexer_st = LX_EOF;
            close_token(TK_EOF);
            consumed = 1'b1;
          end else begin
            lexer_st = LX_BEGIN;
          end
        end
        LX_EOF: begin
          close_token(TK_EOF);
          consumed = 1'b1;
        end
        default: begin
          if (c == CL_OTHER || c == CL_BSLASH || c == CL_DEL) begin
            emit(EvChar, b, TK_STRING);
            consumed = 1'b1;
          end else begin
            lexer_st = LX_BEGIN;
            close_token(TK_ILLEGAL);
          end
        end
      endcase
    end
    if (byte_evs.size() > 0) byte_evs[byte_evs.size() - 1].last = 1'b1;
  endfunction

  // Sends one byte in bursts of random length with random gaps between them, then
  // books the results that the byte must cause.
  task automatic push_byte(input logic [7:0] b, input bit use_typed = 1'b0,
                           input token_ev_t typed_ev = '0);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    lex_byte(b);
    if (byte_evs.size() > 0) productive++;
    if (use_typed) begin
      pending_tokens.push_back(typed_ev);
    end else begin
      foreach (byte_evs[i]) pending_tokens.push_back(byte_evs[i]);
    end
  endtask

  // Holds the input off until every owed result has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_tokens.size() != 0);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = $urandom_range(0, 1) ? 8'h09 : 8'h0C;
      1, 2, 3, 4, 5: begin
        do b = 8'($urandom_range(8'h20, 8'h7E));
        while (b == 8'h22 || b == 8'h2C || b == 8'h5C);
      end
      default: b = 8'($urandom_range(8'h80, 8'hFF));
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ctrl_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 31));
    while (b == 8'h09 || b == 8'h0A || b == 8'h0C || b == 8'h0D || b == 8'h1A);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == 8'h1A);
    return b;
  endfunction

  // One field of a record: mostly well formed, now and then unterminated or garbage.
  task automatic send_field();
    int unsigned n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        n = $urandom_range(0, 5);
        repeat (n) push_byte(plain_byte());
      end
      4, 5, 6: begin
        push_byte(8'h22);
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 7))
            0, 1: push_byte(plain_byte());
            2: push_byte(8'h2C);
            3: begin
              push_byte(8'h22);
              push_byte(8'h22);
            end
            4: begin
              push_byte(8'h5C);
              push_byte(noise_byte());
            end
            5: push_byte($urandom_range(0, 1) ? 8'h0D : 8'h0A);
            6: push_byte(ctrl_byte());
            default: push_byte(8'h7F);
          endcase
        end
        if ($urandom_range(0, 9) != 0) push_byte(8'h22);
      end
      7: begin
        push_byte(8'h7F);
        n = $urandom_range(0, 3);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: push_byte(ctrl_byte());
            1: push_byte(8'h5C);
            default: push_byte(8'h7F);
          endcase
        end
      end
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) push_byte(noise_byte());
      end
      default: ;
    endcase
  endtask

  // A record of comma separated fields closed by a line ending, an escaped LF or nothing.
  task automatic send_record();
    int unsigned nf;
    nf = $urandom_range(1, 6);
    for (int i = 0; i < nf; i++) begin
      send_field();
      if (i < nf - 1) push_byte(8'h2C);
    end
    case ($urandom_range(0, 6))
      0, 1: push_byte(8'h0A);
      2: begin
        push_byte(8'h0D);
        push_byte(8'h0A);
      end
      3: begin
        push_byte(8'h0A);
        push_byte(8'h0A);
      end
      4: begin
        push_byte(8'h0D);
        push_byte(8'h0A);
        push_byte(8'h0D);
        push_byte(8'h0A);
      end
      5: begin
        push_byte(8'h5C);
        push_byte(8'h0A);
      end
      default: ;
    endcase
  endtask

  task automatic flag_field(input string what, input logic [15:0] want_v,
                            input logic [15:0] got_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
  endtask

  // The receiver switches between steady patterns: always ready, coin flips, bit 2 of a
  // free-running cycle counter, and ready only when the counter's low two bits are zero.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  logic [7:0]  stall_cyc = '0;

  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 8'd1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= stall_cyc[2];
      default: m_axis_tready <= (stall_cyc[1:0] == 2'b00);
    endcase
  end

  // Every output transfer is matched against the oldest owed result.
  always @(posedge clk_i) begin : check_out
    token_ev_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_tokens.size() == 0) begin
        flag_field("unexpected result tdata", 16'h0000, m_axis_tdata[15:0]);
      end else begin
        want = pending_tokens.pop_front();
        if (m_axis_tuser !== want.kind) begin
          flag_field("event_kind", 16'(want.kind), 16'(m_axis_tuser));
        end
        if (m_axis_tdata[7:0] !== want.ch) begin
          flag_field("char_value", 16'(want.ch), 16'(m_axis_tdata[7:0]));
        end
        if (m_axis_tdata[10:8] !== want.code) begin
          flag_field("token_code", 16'(want.code), 16'(m_axis_tdata[10:8]));
        end
        if (m_axis_tdata[26:11] !== want.line) begin
          flag_field("line_count", want.line, m_axis_tdata[26:11]);
        end
        if (m_axis_tdata[34:27] !== want.idx) begin
          flag_field("token_index", 16'(want.idx), 16'(m_axis_tdata[34:27]));
        end
        if (m_axis_tdata[39:35] !== 5'd0) begin
          flag_field("tdata pad", 16'h0000, 16'(m_axis_tdata[39:35]));
        end
        if (m_axis_tlast !== want.last) begin
          flag_field("last", 16'(want.last), 16'(m_axis_tlast));
        end
      end
    end
  end

  // Gives up when neither side has moved a transfer for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 IdleLimit, pending_tokens.size());
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned rand_start;
    lexer_st = LX_BEGIN;
    row_no   = 16'd1;
    field_no = 8'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirScript[i]) push_byte(DirScript[i].din, DirScript[i].typed, DirScript[i].ev);
    wait_drained();

    // A line of commas long enough to run the token index into saturation.
    repeat (WideLine) push_byte(8'h2C);
    push_byte(8'h0A);

    rand_start = productive;
    while (productive < rand_start + RandTarget) send_record();
    wait_drained();

    // End of file can only happen once, so the state it arrives in is picked at random.
    case ($urandom_range(0, 6))
      0: push_byte(8'h2C);
      1: push_byte(plain_byte());
      2: begin
        push_byte(8'h22);
        push_byte(plain_byte());
      end
      3: begin
        push_byte(8'h22);
        push_byte(plain_byte());
        push_byte(8'h22);
      end
      4: begin
        push_byte(8'h22);
        push_byte(8'h5C);
      end
      5: push_byte(8'h0A);
      default: push_byte(8'h7F);
    endcase
    push_byte(8'h1A);
    repeat (6) push_byte(8'($urandom_range(0, 255)));

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_tokens.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[csv_byte_tokenizer_top.f]
src/cbt_pkg.sv
src/cbt_front.sv
src/cbt_queue.sv
src/cbt_back.sv
src/csv_byte_tokenizer_top.sv
verif/testbench.sv
